/* rtl/vnoise_pkg.sv */
// ----------------------------------------------------------------------------
// vnoise_pkg
// Shared types, constants and the cosine weight table of the fractal
// value-noise core.
// ----------------------------------------------------------------------------
package vnoise_pkg;

  localparam int MaxOctaves = 16;
  localparam int CntW       = 5;
  localparam int CosDepth   = 256;
  localparam int CosIdxW    = $clog2(CosDepth);
  localparam int Lattice    = 16;

  typedef enum logic [2:0] {
    CfgBaseFreq  = 3'd0,
    CfgLacun     = 3'd1,
    CfgPersist   = 3'd2,
    CfgStartAmp  = 3'd3,
    CfgOctaves   = 3'd4,
    CfgCoverage  = 3'd5,
    CfgDensity   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic [16:0] level;
    logic        clamped;
  } res_t;

  typedef struct packed {
    logic [23:0]        base_frequency;
    logic [17:0]        lacunarity;
    logic [16:0]        persistence;
    logic [17:0]        start_amplitude;
    logic [CntW-1:0]    octave_count;
    logic signed [20:0] coverage_offset;
    logic [19:0]        density_scale;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  px;
    logic [9:0]  py;
    logic [23:0] freq;
    logic [17:0] amp;
    logic        last;
    logic        zero;
  } tok_t;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [17:0] amp;
    logic        last;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic [Lattice-1:0][17:0] vals;
    side_t                    sd;
  } lat_t;

  typedef struct packed {
    logic signed [20:0] w;
    logic               last;
    logic               zero;
  } wt_t;

  typedef logic [16:0] cos_tab_t [CosDepth];

  function automatic logic [16:0] cos_entry(input int unsigned k);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned t;
    longint          a;
    longint unsigned sq;
    u  = (64'd3373259426 * 64'(k)) >> (CosIdxW + 1);
    u2 = (u * u) >> 30;
    t  = u;
    a  = longint'(u);
    t  = ((t * u2) >> 30) / 6;   a = a - longint'(t);
    t  = ((t * u2) >> 30) / 20;  a = a + longint'(t);
    t  = ((t * u2) >> 30) / 42;  a = a - longint'(t);
    t  = ((t * u2) >> 30) / 72;  a = a + longint'(t);
    t  = ((t * u2) >> 30) / 110; a = a - longint'(t);
    t  = ((t * u2) >> 30) / 156; a = a + longint'(t);
    t  = ((t * u2) >> 30) / 210; a = a - longint'(t);
    if (a < 0) a = 0;
    if (a > 64'sd1073741824) a = 64'sd1073741824;
    sq = longint'(a) * longint'(a);
    return 17'((sq + (64'd1 << 43)) >> 44);
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    for (int k = 0; k < CosDepth; k++) begin
      tab[k] = cos_entry(k);
    end
    return tab;
  endfunction

  localparam cos_tab_t CosTab = build_cos_tab();

endpackage

/* rtl/vnoise_seq.sv */
// ----------------------------------------------------------------------------
// vnoise_seq
// Octave sequencer: issues one octave token per cycle for the current pixel,
// stepping frequency and amplitude.
// ----------------------------------------------------------------------------
module vnoise_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  vnoise_pkg::req_t  req_i,
  input  vnoise_pkg::cfg_t  cfg_i,
  output logic              tok_valid_o,
  output vnoise_pkg::tok_t  tok_o
);
  import vnoise_pkg::*;

  logic            active_q;
  logic [CntW-1:0] remain_q, remain_d;
  logic            zero_q;
  logic [9:0]      px_q, py_q;
  logic [23:0]     freq_q, freq_d;
  logic [17:0]     amp_q, amp_d;
  logic            last_w, accept_w;
  logic [CntW-1:0] cnt_w;
  logic [16:0]     pers_w;
  logic [41:0]     fprod_w;
  logic [34:0]     aprod_w;

  assign last_w   = (remain_q == CntW'(1));
  assign busy     = active_q & ~last_w;
  assign accept_w = start & ~busy;

  always_comb begin
    cnt_w = (cfg_i.octave_count > CntW'(MaxOctaves)) ? CntW'(MaxOctaves)
                                                     : cfg_i.octave_count;
    remain_d = (cnt_w == '0) ? CntW'(1) : cnt_w;
    pers_w = (cfg_i.persistence > 17'd65536) ? 17'd65536 : cfg_i.persistence;
    fprod_w = 42'(freq_q) * 42'(cfg_i.lacunarity);
    freq_d  = (|fprod_w[41:40]) ? 24'hffffff : fprod_w[39:16];
    aprod_w = 35'(amp_q) * 35'(pers_w);
    amp_d   = aprod_w[33:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      remain_q <= '0;
    end else if (accept_w) begin
      active_q <= 1'b1;
      remain_q <= remain_d;
    end else if (active_q) begin
      remain_q <= remain_q - CntW'(1);
      if (last_w) active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      zero_q <= (cnt_w == '0);
      px_q   <= req_i.pixel_x;
      py_q   <= req_i.pixel_y;
      freq_q <= cfg_i.base_frequency;
      amp_q  <= cfg_i.start_amplitude;
    end else if (active_q) begin
      freq_q <= freq_d;
      amp_q  <= amp_d;
    end
  end

  assign tok_valid_o = active_q;
  assign tok_o = '{px: px_q, py: py_q, freq: freq_q, amp: amp_q,
                   last: last_w, zero: zero_q};

endmodule

/* rtl/vnoise_lattice.sv */
// ----------------------------------------------------------------------------
// vnoise_lattice
// Scales the coordinate and hashes the 4x4 lattice neighborhood (six stages).
// ----------------------------------------------------------------------------
module vnoise_lattice (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  vnoise_pkg::tok_t  tok_i,
  output logic              valid_o,
  output vnoise_pkg::lat_t  lat_o
);
  import vnoise_pkg::*;

  logic [5:0]  vld_q;
  side_t       sd_q [6];
  logic [17:0] ix_q, iy_q;
  logic [31:0] n0_q;
  logic [31:0] n3_q [Lattice];
  logic [31:0] n4_q [Lattice];
  logic [31:0] sq4_q [Lattice];
  logic [31:0] n5_q [Lattice];
  logic [31:0] q5_q [Lattice];
  logic [Lattice-1:0][17:0] val_q;
  logic [33:0] sx_w, sy_w;

  assign sx_w = 34'(tok_i.px) * 34'(tok_i.freq);
  assign sy_w = 34'(tok_i.py) * 34'(tok_i.freq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[4:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] n;
    logic [31:0] r;
    ix_q <= sx_w[33:16];
    iy_q <= sy_w[33:16];
    sd_q[0] <= '{fx: sx_w[15:0], fy: sy_w[15:0], amp: tok_i.amp,
                 last: tok_i.last, zero: tok_i.zero};
    n0_q <= 32'(ix_q) + 32'(iy_q) * 32'd57 - 32'd58;
    for (int i = 0; i < Lattice; i++) begin
      n = n0_q + 32'(i & 3) + 32'(57 * (i >> 2));
      n3_q[i]  <= (n << 13) ^ n;
      n4_q[i]  <= n3_q[i];
      sq4_q[i] <= n3_q[i] * n3_q[i];
      n5_q[i]  <= n4_q[i];
      q5_q[i]  <= sq4_q[i] * 32'd15731 + 32'd789221;
      r = n5_q[i] * q5_q[i] + 32'd1376312589;
      val_q[i] <= 18'sd65536 - 18'($unsigned(r[30:14]));
    end
    for (int s = 1; s < 6; s++) begin
      sd_q[s] <= sd_q[s-1];
    end
  end

  assign valid_o = vld_q[5];
  assign lat_o   = '{vals: val_q, sd: sd_q[5]};

endmodule

/* rtl/vnoise_interp.sv */
// ----------------------------------------------------------------------------
// vnoise_interp
// 3x3 smoothing, cosine interpolation in X then Y, amplitude weighting.
// ----------------------------------------------------------------------------
module vnoise_interp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  vnoise_pkg::lat_t  lat_i,
  output logic              valid_o,
  output vnoise_pkg::wt_t   wt_o
);
  import vnoise_pkg::*;

  logic [3:0]         vld_q;
  logic signed [17:0] sm_q [4];
  logic [16:0]        wx_q, wy_q, wy8_q;
  logic signed [17:0] i1_q, i2_q, iv_q;
  logic [17:0]        amp_q [3];
  logic [2:0]         last_q, zero_q;
  wt_t                wt_q;

  function automatic logic signed [17:0] g(input lat_t l, input int a, input int b);
    return $signed(l.vals[a + 4 * b]);
  endfunction

  function automatic logic signed [17:0] smooth(input lat_t l, input int cx, input int cy);
    logic signed [22:0] s;
    s = 23'(g(l, cx-1, cy-1)) + 23'(g(l, cx+1, cy-1)) + 23'(g(l, cx-1, cy+1))
      + 23'(g(l, cx+1, cy+1))
      + 23'sd2 * (23'(g(l, cx-1, cy)) + 23'(g(l, cx+1, cy)) + 23'(g(l, cx, cy-1))
                + 23'(g(l, cx, cy+1)))
      + 23'sd4 * 23'(g(l, cx, cy));
    return 18'(s >>> 4);
  endfunction

  function automatic logic signed [17:0] blend(input logic signed [17:0] a,
                                               input logic signed [17:0] b,
                                               input logic [16:0] w);
    logic signed [18:0] wb;
    logic signed [18:0] wa;
    logic signed [37:0] p;
    wb = signed'({2'b00, w});
    wa = 19'sd65536 - wb;
    p  = 38'(a) * 38'(wa) + 38'(b) * 38'(wb);
    return 18'(p >>> 16);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    logic signed [37:0] p;
    sm_q[0] <= smooth(lat_i, 1, 1);
    sm_q[1] <= smooth(lat_i, 2, 1);
    sm_q[2] <= smooth(lat_i, 1, 2);
    sm_q[3] <= smooth(lat_i, 2, 2);
    wx_q <= CosTab[lat_i.sd.fx[15 -: CosIdxW]];
    wy_q <= CosTab[lat_i.sd.fy[15 -: CosIdxW]];
    amp_q[0]  <= lat_i.sd.amp;
    last_q[0] <= lat_i.sd.last;
    zero_q[0] <= lat_i.sd.zero;

    i1_q  <= blend(sm_q[0], sm_q[1], wx_q);
    i2_q  <= blend(sm_q[2], sm_q[3], wx_q);
    wy8_q <= wy_q;

    iv_q <= blend(i1_q, i2_q, wy8_q);

    p = 38'(iv_q) * 38'(signed'({1'b0, amp_q[2]}));
    wt_q <= '{w: 21'(p >>> 16), last: last_q[2], zero: zero_q[2]};

    for (int s = 1; s < 3; s++) begin
      amp_q[s]  <= amp_q[s-1];
      last_q[s] <= last_q[s-1];
      zero_q[s] <= zero_q[s-1];
    end
  end

  assign valid_o = vld_q[3];
  assign wt_o    = wt_q;

endmodule

/* rtl/vnoise_accum.sv */
// ----------------------------------------------------------------------------
// vnoise_accum
// Octave accumulator, coverage offset, density scale and clamp.
// ----------------------------------------------------------------------------
module vnoise_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  vnoise_pkg::wt_t   wt_i,
  input  vnoise_pkg::cfg_t  cfg_i,
  output logic              res_valid_o,
  output vnoise_pkg::res_t  res_o
);
  import vnoise_pkg::*;

  logic signed [24:0] acc_q;
  logic signed [25:0] s1_q;
  logic signed [47:0] p2_q;
  logic [2:0]         vld_q;
  res_t               res_q;
  logic signed [24:0] wz_w;
  logic signed [31:0] scaled_w;

  assign wz_w     = wt_i.zero ? 25'sd0 : 25'(wt_i.w);
  assign scaled_w = 32'(p2_q >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i & wt_i.last};
      if (valid_i) acc_q <= wt_i.last ? 25'sd0 : acc_q + wz_w;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= 26'(acc_q) + 26'(wz_w) + 26'(cfg_i.coverage_offset);
    p2_q <= 48'(s1_q) * 48'(signed'({1'b0, cfg_i.density_scale}));
    if (scaled_w < 0) begin
      res_q <= '{level: 17'd0, clamped: 1'b1};
    end else if (scaled_w > 32'sd65536) begin
      res_q <= '{level: 17'd65536, clamped: 1'b1};
    end else begin
      res_q <= '{level: scaled_w[16:0], clamped: 1'b0};
    end
  end

  assign res_valid_o = vld_q[2];
  assign res_o       = res_q;

endmodule

/* rtl/value_noise_2d_octaves_core.sv */
// ----------------------------------------------------------------------------
// value_noise_2d_octaves_core
// Fractal 2-D value noise with cosine interpolation, Q.16 fixed point.
//
// A pixel request is taken when start is high and busy is low. The core then
// issues one octave per cycle into a 13-stage octave pipeline (coordinate
// scale, lattice index, four hash stages, smoothing, X blend, Y blend,
// weighting, then accumulate with offset, density scale and clamp). A pixel
// with N octaves (N clamped to 1..16, zero treated as one empty pass) holds
// busy until its last octave is issued, so the next pixel can be taken while
// that last octave is issued. The level appears on res_o for one cycle with
// res_valid_o; results cannot be held off and come out in request order.
// Configuration writes go through cfg_valid_i/cfg_ready_o (always ready) and
// must be done while no request is in flight; unknown indexes are dropped.
// Reset restores the default configuration and empties the pipe.
// ----------------------------------------------------------------------------
module value_noise_2d_octaves_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  vnoise_pkg::req_t  req_i,
  output logic              res_valid_o,
  output vnoise_pkg::res_t  res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i
);
  import vnoise_pkg::*;

  cfg_t cfg_q;
  logic tok_valid_w, lat_valid_w, wt_valid_w;
  tok_t tok_w;
  lat_t lat_w;
  wt_t  wt_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{base_frequency: 24'd1245, lacunarity: 18'd65536,
                 persistence: 17'd983, start_amplitude: 18'd58982,
                 octave_count: CntW'(1), coverage_offset: 21'sd58982,
                 density_scale: 20'd39977};
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgBaseFreq: cfg_q.base_frequency  <= cfg_data_i;
        CfgLacun:    cfg_q.lacunarity      <= cfg_data_i[17:0];
        CfgPersist:  cfg_q.persistence     <= cfg_data_i[16:0];
        CfgStartAmp: cfg_q.start_amplitude <= cfg_data_i[17:0];
        CfgOctaves:  cfg_q.octave_count    <= cfg_data_i[CntW-1:0];
        CfgCoverage: cfg_q.coverage_offset <= $signed(cfg_data_i[20:0]);
        CfgDensity:  cfg_q.density_scale   <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  vnoise_seq u_seq (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .cfg_i       (cfg_q),
    .tok_valid_o (tok_valid_w),
    .tok_o       (tok_w)
  );

  vnoise_lattice u_lattice (
    .clk_i, .rst_ni,
    .valid_i (tok_valid_w),
    .tok_i   (tok_w),
    .valid_o (lat_valid_w),
    .lat_o   (lat_w)
  );

  vnoise_interp u_interp (
    .clk_i, .rst_ni,
    .valid_i (lat_valid_w),
    .lat_i   (lat_w),
    .valid_o (wt_valid_w),
    .wt_o    (wt_w)
  );

  vnoise_accum u_accum (
    .clk_i, .rst_ni,
    .valid_i     (wt_valid_w),
    .wt_i        (wt_w),
    .cfg_i       (cfg_q),
    .res_valid_o,
    .res_o
  );

  a_clamp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.clamped |-> res_o.level == 17'd0 || res_o.level == 17'd65536)
    else $error("clamped result not at a bound");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.level <= 17'd65536)
    else $error("level above one");

  a_busy_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cfg_q.octave_count > CntW'(1) |=> busy)
    else $error("multi-octave request did not raise busy");

endmodule
